// ===== rtl/tcw_pkg.sv =====
// Shared constants for the text console writer and its checker.
package tcw_pkg;

   // Command codes on req_command
   localparam logic [1:0] CMD_PRINT = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Register indexes on csr_index
   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;

   // Cell contents
   localparam logic [15:0] BLANK_CELL = 16'h0F00;
   localparam logic [7:0]  TEXT_ATTR  = 8'h0F;
   localparam logic [7:0]  NEWLINE    = 8'd10;

   // Screen limits
   localparam logic [6:0]  MAX_COLUMNS      = 7'd80;
   localparam logic [4:0]  MAX_ROWS         = 5'd25;
   localparam logic [10:0] SCREEN_MAX_CELLS = 11'd2000;

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: character cell store with cursor, print, clear, read and scroll.
//
// Commands enter on start/req_* and are taken at a clock edge where start is high
// and busy is low. Each command gives one result on rsp_* with rsp_strobe high for
// exactly one cycle; the receiver cannot stall, so results are never held.
// Register writes use csr_valid/csr_ready (index 0 columns, 1 rows); csr_ready is
// high only while the block is idle and no command is offered.
// Sequence, from the accepting edge to the strobe cycle:
//   print without scroll, read, unknown command: the state moves to S_RESP, which
//     registers the result; the next command may be offered in the strobe cycle.
//   print that scrolls: S_SETUP, then S_COPY walks the screen through the single
//     read port and single write port of the cell memory, one cell per cycle,
//     then S_BLANK blanks the last row one cell per cycle, then S_RESP.
//   clear: S_CLEAR writes every cell, one memory write per cycle, then S_RESP.
// Reset (synchronous, active high) homes the cursor, sets 80 columns by 25 rows and
// starts a clearing pass that writes blank cells to all CELLS cells; busy stays high
// and no command is taken until it ends (register writes wait as well).
// cursor_location is row*columns+column after the command; scrolled marks a print
// that moved the screen up.
module text_console_writer #(
   parameter int CELLS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_strobe,
   output logic [10:0] rsp_cursor_location,
   output logic [15:0] rsp_read_data,
   output logic        rsp_scrolled,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int AW = $clog2(CELLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_COPY,
      S_BLANK,
      S_RESP
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [AW-1:0]  total_ff, total_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  wr_addr_ff, wr_addr_in;
   logic [6:0]     col_ff, col_in;
   logic [4:0]     row_ff, row_in;
   logic [6:0]     columns_ff, columns_in;
   logic [4:0]     rows_ff, rows_in;
   logic           clear_rsp_ff, clear_rsp_in;
   logic           is_read_ff, is_read_in;
   logic           idx_ok_ff, idx_ok_in;
   logic           scroll_ff, scroll_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [10:0]    rsp_loc_ff, rsp_loc_in;
   logic [15:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_scrolled_ff, rsp_scrolled_in;

   // Cell memory ports
   logic [15:0]    cell_mem [CELLS];
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [15:0]    mem_wd;
   logic [AW-1:0]  mem_ra;
   logic [15:0]    rd_data_ff;

   // Shared multiplier: row*columns for addresses, rows*columns for screen size
   logic [4:0]     mul_a;
   logic [11:0]    mul_p;
   logic [11:0]    cur_addr;

   // Print cursor arithmetic
   logic           is_newline;
   logic [7:0]     col_inc;
   logic [5:0]     row_inc;
   logic           wrap;
   logic           scroll;

   // Register write values
   logic [6:0]     new_cols;
   logic [4:0]     new_rows;

   assign mul_a    = (state_ff == S_SETUP) ? rows_ff : row_ff;
   assign mul_p    = 12'(mul_a) * 12'(columns_ff);
   assign cur_addr = mul_p + 12'(col_ff);

   assign is_newline = (req_char_code == tcw_pkg::NEWLINE);
   assign col_inc    = 8'(col_ff) + 8'd1;
   assign row_inc    = 6'(row_ff) + 6'd1;
   assign wrap       = is_newline || (col_inc >= 8'(columns_ff));
   assign scroll     = wrap && (row_inc >= 6'(rows_ff));

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;

   // Saturated register values for a write (rows use only the low five data bits)
   always_comb begin
      new_cols = columns_ff;
      new_rows = rows_ff;
      if (csr_index == tcw_pkg::CSR_COLUMNS) begin
         if (csr_wdata == 7'd0) new_cols = 7'd1;
         else if (csr_wdata > tcw_pkg::MAX_COLUMNS) new_cols = tcw_pkg::MAX_COLUMNS;
         else new_cols = csr_wdata;
      end
      if (csr_index == tcw_pkg::CSR_ROWS) begin
         if (csr_wdata[4:0] == 5'd0) new_rows = 5'd1;
         else if (csr_wdata[4:0] > tcw_pkg::MAX_ROWS) new_rows = tcw_pkg::MAX_ROWS;
         else new_rows = csr_wdata[4:0];
      end
   end

   // Sequencer next state and memory control
   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      total_in        = total_ff;
      pend_in         = 1'b0;
      wr_addr_in      = wr_addr_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      columns_in      = columns_ff;
      rows_in         = rows_ff;
      clear_rsp_in    = clear_rsp_ff;
      is_read_in      = is_read_ff;
      idx_ok_in       = idx_ok_ff;
      scroll_in       = scroll_ff;
      rsp_strobe_in   = 1'b0;
      rsp_loc_in      = rsp_loc_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_we          = 1'b0;
      mem_wa          = ptr_ff;
      mem_wd          = tcw_pkg::BLANK_CELL;
      mem_ra          = ptr_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == LAST_CELL) begin
               state_in = clear_rsp_ff ? S_RESP : S_IDLE;
            end
         end

         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               columns_in = new_cols;
               rows_in    = new_rows;
               if (col_ff >= new_cols) col_in = new_cols - 7'd1;
               if (row_ff >= new_rows) row_in = new_rows - 5'd1;
            end
            if (start) begin
               is_read_in = 1'b0;
               scroll_in  = 1'b0;
               state_in   = S_RESP;
               mem_ra     = AW'(req_cell_index);
               idx_ok_in  = (32'(req_cell_index) < CELLS);
               case (req_command)
                  tcw_pkg::CMD_PRINT: begin
                     if (!is_newline) begin
                        mem_we = 1'b1;
                        mem_wa = AW'(cur_addr);
                        mem_wd = {tcw_pkg::TEXT_ATTR, req_char_code};
                     end
                     if (wrap) begin
                        col_in = 7'd0;
                        row_in = row_ff + 5'd1;
                     end else begin
                        col_in = col_inc[6:0];
                     end
                     if (scroll) begin
                        row_in    = rows_ff - 5'd1;
                        scroll_in = 1'b1;
                        state_in  = S_SETUP;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     col_in       = 7'd0;
                     row_in       = 5'd0;
                     ptr_in       = '0;
                     clear_rsp_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  tcw_pkg::CMD_READ: begin
                     is_read_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Screen size and copy source start at the second row
         S_SETUP: begin
            total_in = AW'(mul_p);
            ptr_in   = AW'(columns_ff);
            state_in = S_COPY;
         end

         // Read one cell per cycle, write it one row up the cycle after
         S_COPY: begin
            mem_we = pend_ff;
            mem_wa = wr_addr_ff;
            mem_wd = rd_data_ff;
            if (ptr_ff < total_ff) begin
               pend_in    = 1'b1;
               wr_addr_in = ptr_ff - AW'(columns_ff);
               ptr_in     = ptr_ff + AW'(1);
            end else if (!pend_ff) begin
               ptr_in   = total_ff - AW'(columns_ff);
               state_in = S_BLANK;
            end
         end

         // Blank the last row
         S_BLANK: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if ((ptr_ff + AW'(1)) >= total_ff) begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            rsp_strobe_in   = 1'b1;
            rsp_loc_in      = cur_addr[10:0];
            rsp_data_in     = (is_read_ff && idx_ok_ff) ? rd_data_ff : 16'd0;
            rsp_scrolled_in = scroll_ff;
            clear_rsp_in    = 1'b0;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         col_ff        <= 7'd0;
         row_ff        <= 5'd0;
         columns_ff    <= tcw_pkg::MAX_COLUMNS;
         rows_ff       <= tcw_pkg::MAX_ROWS;
         clear_rsp_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         pend_ff       <= pend_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         columns_ff    <= columns_in;
         rows_ff       <= rows_in;
         clear_rsp_ff  <= clear_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      total_ff        <= total_in;
      wr_addr_ff      <= wr_addr_in;
      is_read_ff      <= is_read_in;
      idx_ok_ff       <= idx_ok_in;
      scroll_ff       <= scroll_in;
      rsp_loc_ff      <= rsp_loc_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   // Cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= cell_mem[mem_ra];
   end

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the writer module.
module tcw_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [10:0] rsp_cursor_location,
   input logic [15:0] rsp_read_data,
   input logic        rsp_scrolled
);

   // Reset always starts the clearing pass
   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // An accepted command keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after command transfer");

   // One strobe per transfer: never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A scrolling print returns no cell data, and the cursor stays within the largest screen
   a_scroll_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_scrolled) |-> (rsp_read_data == 16'd0))
      else $error("scrolled result carries read data");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cursor_location < tcw_pkg::SCREEN_MAX_CELLS))
      else $error("cursor outside screen during result");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_cursor_location(rsp_cursor_location),
   .rsp_read_data      (rsp_read_data),
   .rsp_scrolled       (rsp_scrolled)
);
